// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/pcb_pkg.sv =====
// shared types and constants for the polygon centroid block
`timescale 1ns / 1ps
`default_nettype none
package pcb_pkg;
  // accumulator and divider widths, sized for the largest vertex store
  localparam int SW    = 48;   // signed shoelace sum
  localparam int GW    = 64;   // signed weighted sums
  localparam int MAGW  = 47;   // magnitude of shoelace sum
  localparam int D3W   = 49;   // three times the magnitude
  localparam int DENW  = 50;   // divisor, six times the magnitude
  localparam int NUMW  = 74;   // dividend
  localparam int QW    = 25;   // kept quotient bits
  localparam int CNTW  = 7;    // divider step counter

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_CALC   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_DEGEN  = 3'd4;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QW-1:0]   quot;
  } div_res_t;
endpackage
`default_nettype wire

// ===== rtl/polygon_centroid_and_bounds_top.sv =====
// polygon vertex store with shoelace area, centroid and bounding box
// usage:
//   input channel in_*: in_tuser carries the command (add, remove last,
//   clear, compute), in_tdata the point for an add. one transfer per command.
//   result channel out_*: one transfer per command, status in out_tuser,
//   count, area, centroid and box in out_tdata.
// operation:
//   remove and clear need no walk of the store. add walks the store for
//   duplicates. compute runs one shared 17x17 multiplier over each vertex
//   edge, then two restoring divisions, one for each centroid coordinate.
//   in_tready is high only while no command is in progress, one command at
//   a time.
// reset: synchronous active-low, empties the vertex list, no result pending.
//   the vertex memory itself is not cleared.
// stall: the result sits in an output register until out_tready; the next
//   command may be taken meanwhile but its result waits for that register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module polygon_centroid_and_bounds_top #(
  parameter int MAX_POINTS = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // point_x, point_y
  input  wire logic [1:0]   in_tuser,   // cmd
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [159:0]      out_tdata,  // point_count, twice_area, centroid_x,
                                        // centroid_y, box_x_min, box_x_max,
                                        // box_y_min, box_y_max, zero pad
  output logic [2:0]        out_tuser   // status
);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);

  typedef enum logic [4:0] {
    S_IDLE, S_DUP, S_ADD, S_CL_A, S_CL_B, S_V_A, S_V_B,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
    S_FIN, S_DEN, S_DX_ST, S_DX_WT, S_DY_ST, S_DY_WT, S_DONE
  } state_t;

  state_t state_r;

  logic [31:0]  mem [MAX_POINTS];
  logic [31:0]  mem_q_r;
  logic         mem_we;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   pt_r;
  logic          chk_r;
  logic          dup_r;
  logic [2:0]    status_r;
  logic          is_calc_r;

  logic signed [15:0] xj_r, yj_r, xi_r, yi_r;
  logic signed [16:0] sx_r, sy_r;
  logic signed [15:0] xmin_r, xmax_r, ymin_r, ymax_r;
  logic signed [16:0] ma, mb;
  logic signed [33:0] p_r, t_r;
  logic signed [32:0] cr_r;
  logic signed [32:0] cr_new;
  logic signed [pcb_pkg::SW-1:0] s_r;
  logic signed [pcb_pkg::GW-1:0] gx_r, gy_r;
  logic signed [pcb_pkg::GW-1:0] p_ext;
  logic [pcb_pkg::MAGW-1:0] a_r;
  logic [pcb_pkg::GW-1:0]   mgx_r, mgy_r;
  logic [pcb_pkg::D3W-1:0]  den3_r;
  logic                     nx_r, ny_r;
  logic [23:0]              cx_r, cy_r;

  logic                      div_start;
  logic [pcb_pkg::NUMW-1:0]  div_num;
  pcb_pkg::div_res_t         div_res;

  logic signed [15:0] vx_in, vy_in;
  logic [23:0]  lim_x, lim_y, c_mag, c_lim;
  logic         c_neg;
  logic [33:0]  area;
  logic [16:0]  bx_min, bx_max, by_min, by_max;
  logic [CW+8:0] cnt_pad;
  logic          last_v;

  assign in_tready = (state_r == S_IDLE);
  assign vx_in = mem_q_r[31:16];
  assign vy_in = mem_q_r[15:0];
  assign cr_new = 33'(t_r) - 33'(p_r);
  assign p_ext = pcb_pkg::GW'(p_r);
  assign last_v = (idx_r == cnt_r - 1'b1);

  // vertex memory, one write and one registered read port
  assign mem_we = (state_r == S_ADD) && !dup_r && (cnt_r != CW'(MAX_POINTS));
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AW-1:0]] <= pt_r;
    end
    mem_q_r <= mem[idx_r[AW-1:0]];
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_M0: begin ma = 17'(xj_r); mb = 17'(yi_r); end
      S_M1: begin ma = 17'(xi_r); mb = 17'(yj_r); end
      S_M3: begin ma = sx_r; mb = $signed({1'b0, cr_r[15:0]}); end
      S_M4: begin ma = sx_r; mb = cr_r[32:16]; end
      S_M5: begin ma = sy_r; mb = $signed({1'b0, cr_r[15:0]}); end
      S_M6: begin ma = sy_r; mb = cr_r[32:16]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
  end

  assign div_start = (state_r == S_DX_ST) || (state_r == S_DY_ST);
  assign div_num = {1'b0, ((state_r == S_DY_ST) ? mgy_r : mgx_r), 9'd0}
                   + pcb_pkg::NUMW'(den3_r);

  pcb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   ({den3_r, 1'b0}),
    .res   (div_res)
  );

  // saturate the quotient of whichever division just finished
  assign c_neg = (state_r == S_DY_WT) ? ny_r : nx_r;
  assign c_lim = c_neg ? 24'd8388608 : 24'd8388607;
  assign c_mag = (div_res.ovf || (div_res.quot > {1'b0, c_lim})) ? c_lim
                 : div_res.quot[23:0];
  assign lim_x = c_neg ? (24'd0 - c_mag) : c_mag;
  assign lim_y = lim_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      out_tvalid <= 1'b0;
      chk_r      <= 1'b0;
    end else begin
      if (out_tvalid && out_tready && (state_r != S_DONE)) begin
        out_tvalid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          chk_r     <= 1'b0;
          dup_r     <= 1'b0;
          status_r  <= pcb_pkg::ST_OK;
          is_calc_r <= 1'b0;
          pt_r      <= {in_tdata[15:0], in_tdata[31:16]};
          s_r  <= '0;
          gx_r <= '0;
          gy_r <= '0;
          xmin_r <= '0; xmax_r <= '0; ymin_r <= '0; ymax_r <= '0;
          cx_r <= '0;
          cy_r <= '0;
          a_r  <= '0;
          if (in_tvalid) begin
            case (in_tuser)
              pcb_pkg::CMD_ADD: begin
                idx_r   <= '0;
                state_r <= S_DUP;
              end
              pcb_pkg::CMD_REMOVE: begin
                if (cnt_r == '0) begin
                  status_r <= pcb_pkg::ST_EMPTY;
                end else begin
                  cnt_r <= cnt_r - 1'b1;
                end
                state_r <= S_DONE;
              end
              pcb_pkg::CMD_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_DONE;
              end
              default: begin
                is_calc_r <= 1'b1;
                idx_r     <= cnt_r - 1'b1;
                state_r   <= (cnt_r == '0) ? S_FIN : S_CL_A;
              end
            endcase
          end
        end
        S_DUP: begin
          // read issued in the cycle before its compare
          chk_r <= (idx_r < cnt_r);
          if (idx_r < cnt_r) begin
            idx_r <= idx_r + 1'b1;
          end
          if (chk_r && (mem_q_r == pt_r)) begin
            dup_r <= 1'b1;
          end
          if (!(idx_r < cnt_r) && !chk_r) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (dup_r) begin
            status_r <= pcb_pkg::ST_DUP;
          end else if (cnt_r == CW'(MAX_POINTS)) begin
            status_r <= pcb_pkg::ST_FULL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
          state_r <= S_DONE;
        end
        S_CL_A: begin
          state_r <= S_CL_B;
        end
        S_CL_B: begin
          // last vertex starts the edge walk and seeds the box
          xj_r <= vx_in; yj_r <= vy_in;
          xmin_r <= vx_in; xmax_r <= vx_in;
          ymin_r <= vy_in; ymax_r <= vy_in;
          idx_r   <= '0;
          state_r <= S_V_A;
        end
        S_V_A: begin
          state_r <= S_V_B;
        end
        S_V_B: begin
          xi_r <= vx_in;
          yi_r <= vy_in;
          sx_r <= 17'(xj_r) + 17'(vx_in);
          sy_r <= 17'(yj_r) + 17'(vy_in);
          if (vx_in < xmin_r) xmin_r <= vx_in;
          if (vx_in > xmax_r) xmax_r <= vx_in;
          if (vy_in < ymin_r) ymin_r <= vy_in;
          if (vy_in > ymax_r) ymax_r <= vy_in;
          state_r <= S_M0;
        end
        S_M0: state_r <= S_M1;
        S_M1: begin
          t_r     <= p_r;
          state_r <= S_M2;
        end
        S_M2: begin
          cr_r    <= cr_new;
          s_r     <= s_r + pcb_pkg::SW'(cr_new);
          state_r <= S_M3;
        end
        S_M3: state_r <= S_M4;
        S_M4: begin
          gx_r    <= gx_r + p_ext;
          state_r <= S_M5;
        end
        S_M5: begin
          gx_r    <= gx_r + (p_ext <<< 16);
          state_r <= S_M6;
        end
        S_M6: begin
          gy_r    <= gy_r + p_ext;
          state_r <= S_M7;
        end
        S_M7: begin
          gy_r <= gy_r + (p_ext <<< 16);
          xj_r <= xi_r;
          yj_r <= yi_r;
          if (last_v) begin
            state_r <= S_FIN;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_V_A;
          end
        end
        S_FIN: begin
          a_r   <= s_r[pcb_pkg::SW-1] ? pcb_pkg::MAGW'(-s_r) : pcb_pkg::MAGW'(s_r);
          mgx_r <= gx_r[pcb_pkg::GW-1] ? pcb_pkg::GW'(-gx_r) : pcb_pkg::GW'(gx_r);
          mgy_r <= gy_r[pcb_pkg::GW-1] ? pcb_pkg::GW'(-gy_r) : pcb_pkg::GW'(gy_r);
          nx_r  <= gx_r[pcb_pkg::GW-1] != s_r[pcb_pkg::SW-1];
          ny_r  <= gy_r[pcb_pkg::GW-1] != s_r[pcb_pkg::SW-1];
          if (s_r == '0) begin
            status_r <= pcb_pkg::ST_DEGEN;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_DEN;
          end
        end
        S_DEN: begin
          den3_r  <= pcb_pkg::D3W'(a_r) + {a_r, 1'b0};
          state_r <= S_DX_ST;
        end
        S_DX_ST: state_r <= S_DX_WT;
        S_DX_WT: begin
          if (div_res.done) begin
            cx_r    <= lim_x;
            state_r <= S_DY_ST;
          end
        end
        S_DY_ST: state_r <= S_DY_WT;
        S_DY_WT: begin
          if (div_res.done) begin
            cy_r    <= lim_y;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tuser  <= status_r;
            out_tdata  <= is_calc_r
              ? {1'b0, by_max, by_min, bx_max, bx_min, cy_r, cx_r, area, cnt_pad[8:0]}
              : {151'd0, cnt_pad[8:0]};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cnt_pad = {9'd0, cnt_r};
  assign area = (|a_r[pcb_pkg::MAGW-1:34]) ? {34{1'b1}} : a_r[33:0];
  // empty list and single vertex widen the box by one on each side
  assign bx_min = 17'(xmin_r) - ((cnt_r <= CW'(1)) ? 17'd1 : 17'd0);
  assign bx_max = 17'(xmax_r) + ((cnt_r <= CW'(1)) ? 17'd1 : 17'd0);
  assign by_min = 17'(ymin_r) - ((cnt_r <= CW'(1)) ? 17'd1 : 17'd0);
  assign by_max = 17'(ymax_r) + ((cnt_r <= CW'(1)) ? 17'd1 : 17'd0);

  `PCB_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_POINTS))
  `PCB_ASSERT_NEXT(a_busy_after, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `PCB_ASSERT_IMPL(a_degen_zero, clk, rst_n,
    out_tvalid && (out_tuser == pcb_pkg::ST_DEGEN), out_tdata[90:9] == 82'd0)
endmodule
`default_nettype wire

// ===== rtl/pcb_div.sv =====
// restoring divider, one quotient bit per cycle, with quotient overflow flag
`timescale 1ns / 1ps
`default_nettype none
module pcb_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [pcb_pkg::NUMW-1:0] num,
  input  wire logic [pcb_pkg::DENW-1:0] den,
  output pcb_pkg::div_res_t             res
);
  logic [pcb_pkg::DENW-1:0] den_r;
  logic [pcb_pkg::DENW-1:0] rem_r;
  logic [pcb_pkg::NUMW-1:0] nsh_r;
  logic [pcb_pkg::QW-1:0]   q_r;
  logic                     ovf_r;
  logic                     busy_r;
  logic                     done_r;
  logic [pcb_pkg::CNTW-1:0] cnt_r;
  logic [pcb_pkg::DENW:0]   trial;
  logic [pcb_pkg::DENW:0]   diff;
  logic                     qbit;

  assign trial = {rem_r, nsh_r[pcb_pkg::NUMW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        den_r  <= den;
        nsh_r  <= num;
        rem_r  <= '0;
        q_r    <= '0;
        ovf_r  <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[pcb_pkg::DENW-1:0] : trial[pcb_pkg::DENW-1:0];
        nsh_r <= {nsh_r[pcb_pkg::NUMW-2:0], 1'b0};
        // bits shifted past the kept width only mark saturation
        q_r   <= {q_r[pcb_pkg::QW-2:0], qbit};
        ovf_r <= ovf_r | q_r[pcb_pkg::QW-1];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pcb_pkg::CNTW'(pcb_pkg::NUMW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;
endmodule
`default_nettype wire

// ===== test/polygon_centroid_and_bounds_top_tb.sv =====
// testbench for the polygon centroid and bounds block: queued commands, predicted replies
`timescale 1ns / 1ps
`default_nettype none
module polygon_centroid_and_bounds_top_tb;

  localparam int NPTS     = 256;
  localparam int TARGET   = 1150;
  localparam int WD_LIMIT = 40000;
  localparam logic [33:0] AREA_SAT = 34'h3_ffff_ffff;
  localparam longint CENT_POS = 64'd8388607;
  localparam longint CENT_NEG = 64'd8388608;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] x;
    logic [15:0] y;
  } cmd_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [8:0]  count;
    logic [33:0] area;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [16:0] xmin;
    logic [16:0] xmax;
    logic [16:0] ymin;
    logic [16:0] ymax;
  } reply_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;
  logic [2:0]   out_tuser;

  cmd_item_t pending_cmds[$];
  reply_t    expected_replies[$];
  cmd_item_t cur_cmd;
  int        n_errors = 0;
  int        n_accepted = 0;
  int        idle_cycles = 0;
  int        n_queued = 0;

  // shadow of the vertex list
  logic signed [15:0] shadow_x[NPTS];
  logic signed [15:0] shadow_y[NPTS];
  int                 shadow_count = 0;

  always #1 clk = ~clk;

  polygon_centroid_and_bounds_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // round(num * 256 / den), ties away from zero, saturated
  function automatic longint div_fixed8(longint num, longint den, bit neg);
    longint lim, q, r, m;
    lim = neg ? CENT_NEG : CENT_POS;
    q = num / den;
    r = num % den;
    if (q > lim) return lim;
    m = q * 256 + (r * 512 + den) / (2 * den);
    return (m > lim) ? lim : m;
  endfunction

  function automatic reply_t predict_reply(cmd_item_t c);
    reply_t rp;
    bit dup;
    int j;
    longint xi, yi, xj, yj, cr, s, gx, gy, a, den, vcx, vcy;
    longint bx0, bx1, by0, by1;
    bit nx, ny;
    rp = '{default: '0};
    rp.status = pcb_pkg::ST_OK;
    case (c.cmd)
      pcb_pkg::CMD_ADD: begin
        dup = 1'b0;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_x[i] == $signed(c.x) && shadow_y[i] == $signed(c.y)) dup = 1'b1;
        if (dup) rp.status = pcb_pkg::ST_DUP;
        else if (shadow_count >= NPTS) rp.status = pcb_pkg::ST_FULL;
        else begin
          shadow_x[shadow_count] = c.x;
          shadow_y[shadow_count] = c.y;
          shadow_count++;
        end
      end
      pcb_pkg::CMD_REMOVE: begin
        if (shadow_count == 0) rp.status = pcb_pkg::ST_EMPTY;
        else shadow_count--;
      end
      pcb_pkg::CMD_CLEAR: shadow_count = 0;
      default: begin
        if (shadow_count == 0) begin
          bx0 = -1; bx1 = 1; by0 = -1; by1 = 1;
        end else if (shadow_count == 1) begin
          bx0 = shadow_x[0] - 1; bx1 = shadow_x[0] + 1;
          by0 = shadow_y[0] - 1; by1 = shadow_y[0] + 1;
        end else begin
          bx0 = shadow_x[0]; bx1 = shadow_x[0];
          by0 = shadow_y[0]; by1 = shadow_y[0];
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_x[i] < bx0) bx0 = shadow_x[i];
            if (shadow_x[i] > bx1) bx1 = shadow_x[i];
            if (shadow_y[i] < by0) by0 = shadow_y[i];
            if (shadow_y[i] > by1) by1 = shadow_y[i];
          end
        end
        s = 0; gx = 0; gy = 0;
        j = shadow_count - 1;
        for (int i = 0; i < shadow_count; i++) begin
          xi = shadow_x[i]; yi = shadow_y[i]; xj = shadow_x[j]; yj = shadow_y[j];
          cr = xj * yi - xi * yj;
          s += cr;
          gx += (xj + xi) * cr;
          gy += (yj + yi) * cr;
          j = i;
        end
        if (s == 0) rp.status = pcb_pkg::ST_DEGEN;
        else begin
          a = mag(s);
          den = 3 * a;
          nx = (gx < 0) != (s < 0);
          ny = (gy < 0) != (s < 0);
          vcx = div_fixed8(mag(gx), den, nx);
          vcy = div_fixed8(mag(gy), den, ny);
          rp.area = (a > longint'(AREA_SAT)) ? AREA_SAT : a[33:0];
          vcx = nx ? -vcx : vcx;
          vcy = ny ? -vcy : vcy;
          rp.cx = vcx[23:0];
          rp.cy = vcy[23:0];
        end
        rp.xmin = bx0[16:0]; rp.xmax = bx1[16:0];
        rp.ymin = by0[16:0]; rp.ymax = by1[16:0];
      end
    endcase
    rp.count = shadow_count[8:0];
    return rp;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h expected %0h", field, got, want);
    n_errors++;
  endtask

  task automatic queue_cmd(logic [1:0] c, logic [15:0] x, logic [15:0] y);
    pending_cmds.push_back('{cmd: c, x: x, y: y});
    n_queued++;
  endtask

  function automatic logic [15:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 40) - 20);
  endfunction

  function automatic int idle_pct(bit sender);
    if (n_accepted < TARGET / 3) return sender ? 23 : 88;
    if (n_accepted < 2 * TARGET / 3) return sender ? 88 : 23;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    logic      nvalid;
    cmd_item_t nitem;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nvalid = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_replies.push_back(predict_reply(cur_cmd));
        nvalid = 1'b0;
      end
      if (!nvalid && pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
        nitem = pending_cmds.pop_front();
        cur_cmd <= nitem;
        in_tuser <= nitem.cmd;
        in_tdata <= {nitem.y, nitem.x};
        nvalid = 1'b1;
      end
      in_tvalid <= nvalid;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      if (out_tvalid && out_tready) begin
        n_accepted++;
        if (expected_replies.size() == 0) begin
          $display("reply transfer with no command outstanding");
          n_errors++;
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", 64'(out_tuser), 64'(want.status));
          if (out_tdata[8:0] !== want.count)
            report_mismatch("count", 64'(out_tdata[8:0]), 64'(want.count));
          if (out_tdata[42:9] !== want.area)
            report_mismatch("area", 64'(out_tdata[42:9]), 64'(want.area));
          if (out_tdata[66:43] !== want.cx)
            report_mismatch("cx", 64'(out_tdata[66:43]), 64'(want.cx));
          if (out_tdata[90:67] !== want.cy)
            report_mismatch("cy", 64'(out_tdata[90:67]), 64'(want.cy));
          if (out_tdata[107:91] !== want.xmin)
            report_mismatch("xmin", 64'(out_tdata[107:91]), 64'(want.xmin));
          if (out_tdata[124:108] !== want.xmax)
            report_mismatch("xmax", 64'(out_tdata[124:108]), 64'(want.xmax));
          if (out_tdata[141:125] !== want.ymin)
            report_mismatch("ymin", 64'(out_tdata[141:125]), 64'(want.ymin));
          if (out_tdata[158:142] !== want.ymax)
            report_mismatch("ymax", 64'(out_tdata[158:142]), 64'(want.ymax));
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int k, o;
    bit filled;
    // directed
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_REMOVE, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'h8000, 16'h8000);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'h8000, 16'h8000);
    queue_cmd(pcb_pkg::CMD_ADD, 16'h7fff, 16'h8000);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'h7fff, 16'h7fff);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'h8000, 16'h7fff);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_REMOVE, 16'hffff, 16'hffff);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_CLEAR, 16'h1234, 16'h5678);
    // collinear points give zero area
    queue_cmd(pcb_pkg::CMD_ADD, 16'd1, 16'd1);
    queue_cmd(pcb_pkg::CMD_ADD, 16'd2, 16'd2);
    queue_cmd(pcb_pkg::CMD_ADD, 16'd5, 16'd5);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    // clockwise winding
    queue_cmd(pcb_pkg::CMD_CLEAR, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'd0, 16'd0);
    queue_cmd(pcb_pkg::CMD_ADD, 16'd0, 16'd7);
    queue_cmd(pcb_pkg::CMD_ADD, 16'd3, 16'd0);
    queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
    queue_cmd(pcb_pkg::CMD_CLEAR, 16'h0, 16'h0);

    filled = 1'b0;
    while (n_queued < TARGET) begin
      if (!filled && n_queued > TARGET / 2) begin
        // wind around the corners until the store is full, area saturates
        filled = 1'b1;
        queue_cmd(pcb_pkg::CMD_CLEAR, 16'h0, 16'h0);
        for (k = 0; k < NPTS; k++) begin
          o = k / 4;
          case (k % 4)
            0: queue_cmd(pcb_pkg::CMD_ADD, 16'(32767 - o), 16'h7fff);
            1: queue_cmd(pcb_pkg::CMD_ADD, 16'(-32768 + o), 16'h7fff);
            2: queue_cmd(pcb_pkg::CMD_ADD, 16'(-32768 + o), 16'h8000);
            default: queue_cmd(pcb_pkg::CMD_ADD, 16'(32767 - o), 16'h8000);
          endcase
        end
        queue_cmd(pcb_pkg::CMD_ADD, 16'h7fff, 16'h7fff);
        queue_cmd(pcb_pkg::CMD_ADD, 16'h0, 16'h0);
        queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
        queue_cmd(pcb_pkg::CMD_REMOVE, 16'h0, 16'h0);
        queue_cmd(pcb_pkg::CMD_CALC, 16'h0, 16'h0);
      end
      if ($urandom_range(0, 9) == 0)
        queue_cmd(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()));
      else begin
        if ($urandom_range(0, 2) == 0)
          queue_cmd(pcb_pkg::CMD_CLEAR, 16'($urandom()), 16'($urandom()));
        k = $urandom_range(0, 9);
        repeat (k) queue_cmd(pcb_pkg::CMD_ADD, rand_coord(), rand_coord());
        queue_cmd(pcb_pkg::CMD_CALC, 16'($urandom()), 16'($urandom()));
        repeat ($urandom_range(0, 2))
          queue_cmd(pcb_pkg::CMD_REMOVE, 16'($urandom()), 16'($urandom()));
        queue_cmd(pcb_pkg::CMD_CALC, 16'($urandom()), 16'($urandom()));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_tvalid && expected_replies.size() == 0);
    repeat (3000) @(posedge clk);
    if (n_errors == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
